// ===== src/particle_weight_update_and_draw_defines.svh =====
// Assertion macros shared by the particle weight block.
// Used by files that hold concurrent checks; expects clk_i and rst_ni in scope.
`ifndef PARTICLE_WEIGHT_UPDATE_AND_DRAW_DEFINES_SVH
`define PARTICLE_WEIGHT_UPDATE_AND_DRAW_DEFINES_SVH

// check, disabled while reset is held
`define PWUD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that must hold on every edge, reset included
`define PWUD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/pwud_pkg.sv =====
// Shared constants, enums and controller/datapath structs for the particle weight block.
// No dependencies.
`default_nettype none

package pwud_pkg;

  localparam int PARTICLES = 256;            // power of two
  localparam int IDX_W     = $clog2(PARTICLES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int WGT_W     = 24;
  localparam int Q_W       = WGT_W + 1;
  localparam int SUM_W     = WGT_W + IDX_W;
  localparam int DIV_W     = (SUM_W > 32) ? SUM_W : 32;
  localparam int DIV_STEPS = WGT_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [Q_W-1:0]   ONE_Q24 = Q_W'(1) << WGT_W;
  localparam logic [WGT_W-1:0] MAX_Q24 = {WGT_W{1'b1}};
  localparam logic [WGT_W-1:0] INIT_W  = WGT_W'((1 << WGT_W) / PARTICLES);

  typedef enum logic [1:0] {
    DSEL_W,
    DSEL_POST,
    DSEL_NORM
  } div_sel_e;

  typedef enum logic [1:0] {
    RSEL_FRAC,
    RSEL_LAST,
    RSEL_HIT
  } res_sel_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIVW,
    S_WAITW,
    S_DIVP,
    S_WAITP,
    S_BL_RD,
    S_BL_MUL,
    S_BL_WR,
    S_SUM,
    S_SUM_END,
    S_SUM_CHK,
    S_D_MUL,
    S_D_SCAN,
    S_D_OUT,
    S_N_RD,
    S_N_DIV,
    S_N_WAIT,
    S_N_WR
  } ctrl_state_e;

  typedef struct packed {
    logic             load;       // accept input word
    logic             div_start;
    div_sel_e         div_sel;
    logic             w_ld;
    logic             rd_en;
    logic             wr_en;
    logic             use_item;   // address is the blended particle
    logic [IDX_W-1:0] addr;
    logic             wr_norm;    // write normalized value, else blend
    logic             acc_clr;
    logic             acc_en;
    logic             sum_ld;
    logic             prod_ld;
    logic             tgt_ld;
    logic             res_ld;
    res_sel_e         res_sel;
    logic             out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic in_draw;
    logic in_ok;
    logic last;
    logic is_draw;
    logic div_busy;
    logic div_done;
    logic acc_zero;
    logic hit;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/particle_weight_update_and_draw.sv =====
// Particle weight update and roulette-wheel draw: top level.
// Slave stream takes update and draw words. Update (tuser=0): tdata carries
// pair_count, action_count, total_iterations; tlast ends a run, and a valid
// last word triggers renormalization. Draw (tuser=1): tdata carries
// random_fraction and one chosen_index word goes out on the master stream.
// An update with zero action count or total leaves the weights unchanged;
// otherwise two 24-step divisions run before the blend is written back.
// Renormalization after the last word sums the weights, then divides each
// weight by the sum on the shared divider, one divider step per cycle. A draw
// sums the weights and forms the target, then scans the single-port weight
// memory up to the hit or the last entry before its result is loaded.
// One word is worked at a time; tready is high only between words.
// Reset sets every weight to 1/N (through per-entry valid bits, no clearing
// pass) and the update position to 0. A stalled master holds the result in
// the output register; the block takes the next word meanwhile and waits only
// if a second draw result is ready before the first has left.
// Depends on pwud_pkg, pwud_ctrl, pwud_dp, pwud_div.
`default_nettype none

module particle_weight_update_and_draw (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [119:0] s_axis_tdata_i,  // pair_count[31:0], action_count[63:32],
                                             // total_iterations[95:64],
                                             // random_fraction[119:96]
  input  wire logic         s_axis_tuser_i,  // opcode
  input  wire logic         s_axis_tlast_i,  // last_particle
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o   // chosen_index[7:0]
);
  import pwud_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pwud_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pwud_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .in_last_i  (s_axis_tlast_i),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ===== src/pwud_div.sv =====
// Restoring divider, one quotient bit per cycle, fractional quotient of num/den.
// Depends on pwud_pkg; requires num < den for a meaningful result.
`default_nettype none

module pwud_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [pwud_pkg::DIV_W-1:0] num_i,
  input  wire logic [pwud_pkg::DIV_W-1:0] den_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [pwud_pkg::WGT_W-1:0]      quot_o
);
  import pwud_pkg::*;

  logic [DIV_W-1:0]  rem_q, den_q;
  logic [WGT_W-1:0]  quot_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DIV_W:0]    sh;
  logic              qbit;

  assign sh   = {rem_q, 1'b0};
  assign qbit = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q  <= qbit ? DIV_W'(sh - {1'b0, den_q}) : DIV_W'(sh);
      quot_q <= {quot_q[WGT_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DCNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== src/pwud_dp.sv =====
// Datapath: weight memory, input word registers, divider, blend multipliers,
// running sum, draw target and output register. Depends on pwud_pkg, pwud_div.
`default_nettype none

module pwud_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pwud_pkg::dp_cmd_t cmd_i,
  output pwud_pkg::dp_sts_t      sts_o,
  input  wire logic [119:0]      in_data_i,  // pair_count, action_count, total_iterations,
                                             // random_fraction
  input  wire logic              in_user_i,  // opcode
  input  wire logic              in_last_i,  // last_particle
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [7:0]             out_data_o  // chosen_index
);
  import pwud_pkg::*;

  logic [31:0]      pair_q, act_q, tot_q;
  logic [WGT_W-1:0] frac_q;
  logic             draw_q, last_q;
  logic [IDX_W-1:0] pos_q, item_q;

  logic [WGT_W-1:0] mem [PARTICLES];
  logic [PARTICLES-1:0] vld_q;
  logic [WGT_W-1:0] rd_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic [WGT_W-1:0] rdata, wdata;
  logic [IDX_W-1:0] addr;

  logic [DIV_W-1:0] div_num, div_den;
  logic             div_busy, div_done, ge_q;
  logic [WGT_W-1:0] div_quot;
  logic [Q_W-1:0]   q_q, w_q, omw;

  logic [48:0] p1_q;
  logic [49:0] p2_q;
  logic [50:0] mix_sum;
  logic [26:0] mix;
  logic [WGT_W-1:0] blend_w, norm_w;

  logic [SUM_W-1:0] acc_q, acc_nxt, sum_q, tgt_q;
  logic [WGT_W+SUM_W-1:0] tprod;
  logic [IDX_W-1:0] res_q;
  logic             out_valid_q;
  logic [7:0]       out_data_q;

  // input word registers and update position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pair_q <= in_data_i[31:0];
      act_q  <= in_data_i[63:32];
      tot_q  <= in_data_i[95:64];
      frac_q <= in_data_i[119:96];
      draw_q <= in_user_i;
      last_q <= in_last_i;
      item_q <= pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.load && !in_user_i) begin
      if (in_last_i || pos_q == IDX_W'(PARTICLES - 1)) pos_q <= '0;
      else pos_q <= pos_q + IDX_W'(1);
    end
  end

  // weight memory; entries never written read as 1/N
  assign addr  = cmd_i.use_item ? item_q : cmd_i.addr;
  assign wdata = cmd_i.wr_norm ? norm_w : blend_w;
  assign rdata = rd_vld_q ? rd_q : INIT_W;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[addr] <= wdata;
    if (cmd_i.rd_en) rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (cmd_i.wr_en) vld_q[addr] <= 1'b1;
      if (cmd_i.rd_en) begin
        rd_vld_q  <= vld_q[addr];
        rd_addr_q <= addr;
      end
    end
  end

  // divider operands
  always_comb begin
    case (cmd_i.div_sel)
      DSEL_W: begin
        div_num = DIV_W'(act_q);
        div_den = DIV_W'(tot_q);
      end
      DSEL_POST: begin
        div_num = DIV_W'(pair_q);
        div_den = DIV_W'(act_q);
      end
      DSEL_NORM: begin
        div_num = DIV_W'(rdata);
        div_den = DIV_W'(sum_q);
      end
      default: begin
        div_num = '0;
        div_den = '1;
      end
    endcase
  end

  pwud_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // quotient held at 1.0 when the ratio is not below one
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) ge_q <= div_num >= div_den;
    if (div_done) q_q <= ge_q ? ONE_Q24 : {1'b0, div_quot};
    if (cmd_i.w_ld) w_q <= q_q;
  end

  // blend: ((1-w)*old + w*post) >> 24
  assign omw = ONE_Q24 - w_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_ld) begin
      p1_q <= {24'b0, omw} * {25'b0, rdata};
      p2_q <= {25'b0, w_q} * {25'b0, q_q};
    end
  end

  assign mix_sum = {2'b0, p1_q} + {1'b0, p2_q};
  assign mix     = mix_sum[50:24];
  assign blend_w = (|mix[26:24]) ? MAX_Q24 : mix[23:0];
  assign norm_w  = q_q[WGT_W] ? MAX_Q24 : q_q[WGT_W-1:0];

  // running sum, draw target and scan
  assign acc_nxt = acc_q + SUM_W'(rdata);
  assign tprod   = {{SUM_W{1'b0}}, frac_q} * {{WGT_W{1'b0}}, sum_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.acc_en) acc_q <= acc_nxt;
    if (cmd_i.sum_ld) sum_q <= acc_q;
    if (cmd_i.tgt_ld) tgt_q <= tprod[WGT_W +: SUM_W];
    if (cmd_i.res_ld) begin
      case (cmd_i.res_sel)
        RSEL_FRAC: res_q <= frac_q[IDX_W-1:0];   // mod N by mask
        RSEL_LAST: res_q <= IDX_W'(PARTICLES - 1);
        RSEL_HIT:  res_q <= rd_addr_q;
        default:   res_q <= IDX_W'(PARTICLES - 1);
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) out_data_q <= 8'(res_q);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.in_draw  = in_user_i;
  assign sts_o.in_ok    = (in_data_i[63:32] != 32'd0) && (in_data_i[95:64] != 32'd0);
  assign sts_o.last     = last_q;
  assign sts_o.is_draw  = draw_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.acc_zero = acc_q == '0;
  assign sts_o.hit      = acc_nxt >= tgt_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== src/pwud_ctrl.sv =====
// Controller state machine: sequences blend, sum, normalize and draw passes.
// Depends on pwud_pkg and the assertion macro header.
`default_nettype none
`include "particle_weight_update_and_draw_defines.svh"

module pwud_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pwud_pkg::dp_sts_t sts_i,
  output pwud_pkg::dp_cmd_t      cmd_o
);
  import pwud_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q;   // read data arrives this cycle
  logic             cnt_last;

  assign cnt_last = cnt_q == CNT_W'(PARTICLES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= cmd_o.rd_en && !cmd_o.use_item;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          if (sts_i.in_draw) state_d = S_SUM;
          else if (sts_i.in_ok) state_d = S_DIVW;
        end
      end
      S_DIVW:  state_d = S_WAITW;
      S_WAITW: if (sts_i.div_done) state_d = S_DIVP;
      S_DIVP:  state_d = S_WAITP;
      S_WAITP: if (sts_i.div_done) state_d = S_BL_RD;
      S_BL_RD:  state_d = S_BL_MUL;
      S_BL_MUL: state_d = S_BL_WR;
      S_BL_WR: begin
        cnt_d   = '0;
        state_d = sts_i.last ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_last) state_d = S_SUM_END;
      end
      S_SUM_END: state_d = S_SUM_CHK;
      S_SUM_CHK: begin
        cnt_d = '0;
        if (sts_i.is_draw) state_d = sts_i.acc_zero ? S_D_OUT : S_D_MUL;
        else state_d = sts_i.acc_zero ? S_IDLE : S_N_RD;
      end
      S_D_MUL: begin
        cnt_d   = '0;
        state_d = S_D_SCAN;
      end
      S_D_SCAN: begin
        if (pend_q && sts_i.hit) begin
          state_d = S_D_OUT;
        end else if (cnt_q != CNT_W'(PARTICLES)) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          state_d = S_D_OUT;
        end
      end
      S_D_OUT: if (sts_i.out_free) state_d = S_IDLE;
      S_N_RD:   state_d = S_N_DIV;
      S_N_DIV:  state_d = S_N_WAIT;
      S_N_WAIT: if (sts_i.div_done) state_d = S_N_WR;
      S_N_WR: begin
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_N_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DSEL_W;
    cmd_o.res_sel = RSEL_LAST;
    cmd_o.addr    = cnt_q[IDX_W-1:0];
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_valid_i;
        cmd_o.acc_clr = 1'b1;
      end
      S_DIVW: cmd_o.div_start = 1'b1;
      S_DIVP: begin
        cmd_o.w_ld      = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DSEL_POST;
      end
      S_BL_RD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.use_item = 1'b1;
      end
      S_BL_MUL: cmd_o.prod_ld = 1'b1;
      S_BL_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.use_item = 1'b1;
        cmd_o.acc_clr  = 1'b1;
      end
      S_SUM: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.acc_en = pend_q;
      end
      S_SUM_END: cmd_o.acc_en = pend_q;
      S_SUM_CHK: begin
        cmd_o.sum_ld  = 1'b1;
        cmd_o.res_ld  = sts_i.is_draw && sts_i.acc_zero;
        cmd_o.res_sel = RSEL_FRAC;
      end
      S_D_MUL: begin
        cmd_o.tgt_ld  = 1'b1;
        cmd_o.acc_clr = 1'b1;
        cmd_o.res_ld  = 1'b1;
        cmd_o.res_sel = RSEL_LAST;
      end
      S_D_SCAN: begin
        cmd_o.acc_en = pend_q;
        if (pend_q && sts_i.hit) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = RSEL_HIT;
        end else if (cnt_q != CNT_W'(PARTICLES)) begin
          cmd_o.rd_en = 1'b1;
        end
      end
      S_D_OUT: cmd_o.out_ld = sts_i.out_free;
      S_N_RD:  cmd_o.rd_en = 1'b1;
      S_N_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DSEL_NORM;
      end
      S_N_WAIT: cmd_o.div_sel = DSEL_NORM;
      S_N_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_norm = 1'b1;
      end
      default: ;
    endcase
  end

  `PWUD_ASSERT(a_out_free, cmd_o.out_ld |-> sts_i.out_free, "result loaded over a held word")
  `PWUD_ASSERT(a_div_idle, cmd_o.div_start |-> !sts_i.div_busy, "divider restarted while busy")
  `PWUD_ASSERT(a_cnt_range, cnt_q <= CNT_W'(PARTICLES), "pass counter out of range")
  `PWUD_ASSERT_ALWAYS(a_one_port, !(cmd_o.rd_en && cmd_o.wr_en), "read and write in one cycle")

endmodule

`default_nettype wire

// ===== bench/particle_weight_update_and_draw_tb.sv =====
// Self-checking bench for particle_weight_update_and_draw: weight blending,
// renormalization and roulette draws against an in-bench predictor.
// Depends on pwud_pkg and the block's RTL.
`timescale 1ns / 100ps

module particle_weight_update_and_draw_tb;
  import pwud_pkg::*;

  localparam int WDOG_LIMIT = 40000;
  localparam int DRAIN_CYC  = 9000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [119:0] s_axis_tdata_i = '0;  // pair_count, action_count, total_iterations,
                                      // random_fraction
  logic         s_axis_tuser_i = 1'b0; // opcode
  logic         s_axis_tlast_i = 1'b0; // last_particle
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [7:0]   m_axis_tdata_o;       // chosen_index

  particle_weight_update_and_draw uut (.*);

  initial forever #5 clk_i = ~clk_i;

  // predictor state
  logic [WGT_W-1:0] wgt_mem [PARTICLES];
  int unsigned      upd_pos;
  logic [7:0]       idx_q [$];

  int errors = 0;
  int src_idle = 0;
  int snk_stall = 0;
  int holdoff = 0;

  function automatic logic [63:0] total_weight();
    logic [63:0] s = 0;
    for (int i = 0; i < PARTICLES; i++) s += wgt_mem[i];
    return s;
  endfunction

  function automatic void predict_update(logic [31:0] pair, logic [31:0] act,
                                         logic [31:0] tot, logic last);
    logic [63:0] w, post, mix, s, q;
    logic ok;
    ok = (act != 0) && (tot != 0);
    if (ok) begin
      w = (act >= tot) ? 64'(ONE_Q24) : ({32'd0, act} << 24) / tot;
      post = (pair >= act) ? 64'(ONE_Q24) : ({32'd0, pair} << 24) / act;
      mix = ((64'(ONE_Q24) - w) * wgt_mem[upd_pos] + w * post) >> 24;
      wgt_mem[upd_pos] = (mix > MAX_Q24) ? MAX_Q24 : mix[WGT_W-1:0];
    end
    if (last) begin
      s = total_weight();
      if (ok && s != 0)
        for (int i = 0; i < PARTICLES; i++) begin
          q = ({40'd0, wgt_mem[i]} << 24) / s;
          wgt_mem[i] = (q > MAX_Q24) ? MAX_Q24 : q[WGT_W-1:0];
        end
      upd_pos = 0;
    end else begin
      upd_pos = (upd_pos + 1) % PARTICLES;
    end
  endfunction

  function automatic logic [7:0] predict_draw(logic [23:0] frac);
    logic [63:0] s, tgt, acc;
    s = total_weight();
    if (s == 0) return 8'(frac % PARTICLES);
    tgt = ({40'd0, frac} * s) >> 24;
    acc = 0;
    for (int i = 0; i < PARTICLES; i++) begin
      acc += wgt_mem[i];
      if (acc >= tgt) return 8'(i);
    end
    return 8'(PARTICLES - 1);
  endfunction

  // Called right after a falling edge; returns right after a falling edge
  // with tvalid still high, so back-to-back words keep valid high unless idle cycles are injected.
  task automatic send_word(logic op, logic [31:0] pair, logic [31:0] act,
                           logic [31:0] tot, logic [23:0] frac, logic last);
    while (src_idle > 0 && $urandom_range(99) < src_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tlast_i  <= last;
    s_axis_tdata_i  <= {frac, tot, act, pair};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (op) idx_q.push_back(predict_draw(frac));
    else predict_update(pair, act, tot, last);
    @(negedge clk_i);
  endtask

  task automatic send_draw(logic [23:0] frac);
    send_word(1'b1, $urandom, $urandom, $urandom, frac, $urandom_range(1));
  endtask

  task automatic send_rand_update(logic last);
    logic [31:0] p, a, t;
    case ($urandom_range(9))
      0, 1: begin p = $urandom; a = $urandom; t = $urandom; end
      2: begin p = $urandom; a = 0; t = $urandom; end
      3: begin p = $urandom; a = $urandom; t = 0; end
      default: begin
        a = $urandom_range(1, 5000);
        t = a + $urandom_range(0, 5000) - $urandom_range(0, 200);
        if (t == 0) t = 1;
        p = $urandom_range(0, a + 50);
      end
    endcase
    send_word(1'b0, p, a, t, $urandom, last);
  endtask

  task automatic idle_src();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    idle_src();
    while (idx_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_draw(24'h000000);
    send_draw(24'hFFFFFF);
    send_draw(24'h800000);
    send_word(1'b0, 32'd5, 32'd0, 32'd10, 24'h0, 1'b0);   // zero action count
    send_word(1'b0, 32'd5, 32'd10, 32'd0, 24'h0, 1'b0);   // zero total
    send_word(1'b0, 32'd9, 32'd3, 32'd2, 24'h0, 1'b0);    // both ratios held at one
    send_word(1'b0, '1, '1, '1, 24'h0, 1'b0);
    send_word(1'b0, 32'd1, 32'd2, '1, 24'h0, 1'b0);
    send_word(1'b0, 32'd0, 32'd7, 32'd100, 24'h0, 1'b1);  // ends run, renormalizes
    send_draw(24'h000001);
    send_draw(24'hFFFFFF);
    send_word(1'b0, 32'd1, 32'd0, 32'd0, 24'h0, 1'b1);    // invalid last: no renorm
    send_word(1'b0, 32'd3, 32'd4, 32'd4, 24'h0, 1'b1);    // one-item run
    send_draw(24'h400000);
    send_draw(24'hC00000);
    drain();
  endtask

  task automatic test_zero_sum();
    // force every weight to zero, then draws fall back to frac mod N
    for (int i = 0; i < PARTICLES; i++)
      send_word(1'b0, 32'd0, 32'd1, 32'd1, 24'h0, i == PARTICLES - 1);
    for (int i = 0; i < 6; i++) send_draw($urandom);
    send_draw(24'hFFFFFF);
    // revive a few weights
    for (int i = 0; i < 12; i++)
      send_word(1'b0, 32'd1 + $urandom_range(50), 32'd60, 32'd60, 24'h0, i == 11);
    send_draw($urandom);
    drain();
  endtask

  task automatic test_wrap();
    // run past the end without a last mark
    for (int i = 0; i < PARTICLES + 40; i++) send_rand_update(1'b0);
    send_draw($urandom);
    send_rand_update(1'b1);
    send_draw($urandom);
    drain();
  endtask

  task automatic test_random(int n);
    int sent = 0;
    int len;
    while (sent < n) begin
      if ($urandom_range(2) == 0) begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) send_rand_update(i == len - 1);
        sent += len;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_draw($urandom);
        sent += len;
      end
      if ($urandom_range(7) == 0) begin
        send_word($urandom_range(1), $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(1));
        sent++;
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    holdoff = 3000;
    for (int i = 0; i < 8; i++) send_draw($urandom);
    send_rand_update(1'b1);
    send_draw($urandom);
    drain();
  endtask

  // receiver
  always @(negedge clk_i) begin
    if (holdoff > 0) begin
      holdoff <= holdoff - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !(snk_stall > 0 && $urandom_range(99) < snk_stall);
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (idx_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d", $realtime,
                 m_axis_tdata_o);
        errors++;
      end else begin
        if (m_axis_tdata_o !== idx_q[0]) begin
          $display("%0t: chosen_index mismatch, expected %0d, actual %0d",
                   $realtime, idx_q[0], m_axis_tdata_o);
          errors++;
        end
        void'(idx_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no word moved on either side
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < PARTICLES; i++) wgt_mem[i] = INIT_W;
    upd_pos = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_zero_sum();
    src_idle = 46;
    test_wrap();
    src_idle = 0;  snk_stall = 0;  test_random(200);
    src_idle = 46; snk_stall = 0;  test_random(150);
    src_idle = 0;  snk_stall = 46; test_random(150);
    src_idle = 17; snk_stall = 17; test_random(150);
    src_idle = 0;  snk_stall = 0;  test_backpressure();
    test_random(80);

    drain();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (errors == 0 && idx_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (idx_q.size() != 0)
        $display("%0t: %0d expected words never arrived", $realtime, idx_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
